// ===== design/assert_macros.svh =====
// Assertion macros shared by the fixed-point unit RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define FPA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define FPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/fpa_pkg.sv =====
// Shared types and constants of the fixed-point unit.
// No dependencies; used by every module of the block.
package fpa_pkg;

    localparam int unsigned FracBitsDefault = 8;
    localparam int unsigned WordW           = 32;

    typedef enum logic [3:0] {
        CMD_ADD      = 4'd0,
        CMD_SUB      = 4'd1,
        CMD_MUL      = 4'd2,
        CMD_DIV      = 4'd3,
        CMD_GT       = 4'd4,
        CMD_LT       = 4'd5,
        CMD_GE       = 4'd6,
        CMD_LE       = 4'd7,
        CMD_EQ       = 4'd8,
        CMD_NE       = 4'd9,
        CMD_MIN      = 4'd10,
        CMD_MAX      = 4'd11,
        CMD_INC      = 4'd12,
        CMD_DEC      = 4'd13,
        CMD_FROM_INT = 4'd14,
        CMD_TO_INT   = 4'd15
    } t_cmd;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_true;
        logic               divide_by_zero;
        logic               overflowed;
    } t_out_item;

    // Front stage output: simple results plus raw product and divide setup.
    typedef struct packed {
        t_cmd               cmd;
        logic [31:0]        result;
        logic               cmp;
        logic               ovf;
        logic               dz;
        logic               neg;
        logic signed [63:0] product;
        logic [31:0]        a_mag;
        logic [31:0]        b_mag;
    } t_front;

    // Sideband carried alongside the divider stages.
    typedef struct packed {
        logic        is_div;
        logic        neg;
        logic        dz;
        logic [31:0] result;
        logic        cmp;
        logic        ovf;
    } t_side;

endpackage

// ===== design/fpa_front.sv =====
// First pipeline stage: decode, simple ops, multiply and divide setup.
// Depends on fpa_pkg.
module fpa_front import fpa_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDefault
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_item i_data,
    output logic     o_valid,
    output t_front   o_data
);

    logic               r_valid;
    t_front             r_data;
    t_front             n_data;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic [32:0]        w_sum;
    logic [32:0]        w_diff;
    logic [32:0]        w_inc;
    logic [32:0]        w_dec;
    logic signed [31:0] w_bias;
    logic signed [31:0] w_toint;
    logic [FRAC_BITS:0] w_top;

    always_comb begin
        w_a     = i_data.operand_a;
        w_b     = i_data.operand_b;
        w_sum   = {w_a[31], w_a} + {w_b[31], w_b};
        w_diff  = {w_a[31], w_a} - {w_b[31], w_b};
        w_inc   = {w_a[31], w_a} + 33'd1;
        w_dec   = {w_a[31], w_a} - 33'd1;
        w_bias  = w_a[31] ? 32'((64'd1 << FRAC_BITS) - 64'd1) : '0;
        w_toint = (w_a + w_bias) >>> FRAC_BITS;
        w_top   = w_a[31:31-FRAC_BITS];

        n_data         = '0;
        n_data.cmd     = t_cmd'(i_data.cmd);
        n_data.product = w_a * w_b;
        n_data.neg     = w_a[31] ^ w_b[31];
        n_data.a_mag   = w_a[31] ? 32'(-w_a) : 32'(w_a);
        n_data.b_mag   = w_b[31] ? 32'(-w_b) : 32'(w_b);
        case (t_cmd'(i_data.cmd))
            CMD_ADD: begin
                n_data.result = w_sum[31:0];
                n_data.ovf    = w_sum[32] ^ w_sum[31];
            end
            CMD_SUB: begin
                n_data.result = w_diff[31:0];
                n_data.ovf    = w_diff[32] ^ w_diff[31];
            end
            CMD_DIV:  n_data.dz  = (w_b == '0);
            CMD_GT:   n_data.cmp = (w_a > w_b);
            CMD_LT:   n_data.cmp = (w_a < w_b);
            CMD_GE:   n_data.cmp = (w_a >= w_b);
            CMD_LE:   n_data.cmp = (w_a <= w_b);
            CMD_EQ:   n_data.cmp = (w_a == w_b);
            CMD_NE:   n_data.cmp = (w_a != w_b);
            CMD_MIN:  n_data.result = (w_a < w_b) ? w_a : w_b;
            CMD_MAX:  n_data.result = (w_a > w_b) ? w_a : w_b;
            CMD_INC: begin
                n_data.result = w_inc[31:0];
                n_data.ovf    = w_inc[32] ^ w_inc[31];
            end
            CMD_DEC: begin
                n_data.result = w_dec[31:0];
                n_data.ovf    = w_dec[32] ^ w_dec[31];
            end
            CMD_FROM_INT: begin
                n_data.result = w_a << FRAC_BITS;
                // overflow unless the bits shifted out all match the new sign
                n_data.ovf    = !((&w_top) || !(|w_top));
            end
            CMD_TO_INT: n_data.result = w_toint;
            default: n_data.result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== design/fpa_divider.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on fpa_pkg; carries an opaque sideband word alongside each item.
module fpa_divider import fpa_pkg::*; #(
    parameter int unsigned DW     = 40,
    parameter int unsigned SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_dividend,
    input  logic [31:0]       i_divisor,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [DW-1:0]     o_quotient,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_valid [DW];
    logic [31:0]       r_rem   [DW];
    logic [DW-1:0]     r_nq    [DW];
    logic [31:0]       r_d     [DW];
    logic [SIDE_W-1:0] r_side  [DW];

    for (genvar k = 0; k < DW; k++) begin : g_stage
        logic              w_valid;
        logic [31:0]       w_rem;
        logic [DW-1:0]     w_nq;
        logic [31:0]       w_d;
        logic [SIDE_W-1:0] w_side;
        logic [32:0]       w_shift;
        logic              w_ge;
        logic [32:0]       w_sub;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_rem   = '0;
            assign w_nq    = i_dividend;
            assign w_d     = i_divisor;
            assign w_side  = i_side;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_rem   = r_rem[k-1];
            assign w_nq    = r_nq[k-1];
            assign w_d     = r_d[k-1];
            assign w_side  = r_side[k-1];
        end

        // bring down the next dividend bit, subtract when it fits
        assign w_shift = {w_rem, w_nq[DW-1]};
        assign w_ge    = (w_shift >= {1'b0, w_d});
        assign w_sub   = w_shift - {1'b0, w_d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_sub[31:0] : w_shift[31:0];
                r_nq[k]   <= {w_nq[DW-2:0], w_ge};
                r_d[k]    <= w_d;
                r_side[k] <= w_side;
            end
        end
    end

    assign o_valid    = r_valid[DW-1];
    assign o_quotient = r_nq[DW-1];
    assign o_side     = r_side[DW-1];

endmodule

// ===== design/fixed_point_alu.sv =====
// Top level of the fixed-point unit: front stage, multiply rounding stage,
// divider pipeline and output register. Depends on fpa_pkg, fpa_front, fpa_divider.
//
//  channel | valid      | ready       | payload
//  input   | i_in_valid | o_in_ready  | i_in_data  (t_in_item)
//  output  | o_out_valid| i_out_ready | o_out_data (t_out_item)
//
// One item per cycle unless the output stalls. Items pass the front stage,
// multiply stage, 32 + FRAC_BITS divider bit stages and output register.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A stall at the output freezes the whole pipeline, so nothing moves or drops.
`include "assert_macros.svh"

module fixed_point_alu import fpa_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int unsigned DivW  = WordW + FRAC_BITS;
    localparam int unsigned SideW = $bits(t_side);

    logic               w_adv;
    logic               w_front_valid;
    t_front             w_front;
    logic               r_mv;
    t_side              r_side;
    t_side              n_side;
    logic [DivW-1:0]    r_dividend;
    logic [31:0]        r_divisor;
    logic signed [63:0] w_bias;
    logic signed [63:0] w_mul;
    logic               w_div_valid;
    logic [DivW-1:0]    w_quot;
    logic [SideW-1:0]   w_side_bits;
    t_side              w_side;
    logic               r_out_valid;
    t_out_item          r_out;
    t_out_item          n_out;
    logic [31:0]        w_qlow;
    logic               w_out_dz;
    logic               w_out_cmp;
    logic               w_res_clean;
    logic               w_cmp_clean;

    // advance every stage unless the output holds an untaken result
    assign w_adv      = !r_out_valid || i_out_ready;
    assign o_in_ready = w_adv;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_in_valid),
        .i_data  (i_in_data),
        .o_valid (w_front_valid),
        .o_data  (w_front)
    );

    // truncate the product toward zero, then check it fits the word
    always_comb begin
        w_bias = w_front.product[63] ? 64'((65'd1 << FRAC_BITS) - 65'd1) : '0;
        w_mul  = w_front.product + w_bias;

        n_side        = '0;
        n_side.is_div = (w_front.cmd == CMD_DIV);
        n_side.neg    = w_front.neg;
        n_side.dz     = w_front.dz;
        n_side.cmp    = w_front.cmp;
        if (w_front.cmd == CMD_MUL) begin
            n_side.result = w_mul[31+FRAC_BITS:FRAC_BITS];
            n_side.ovf    = !((&w_mul[63:31+FRAC_BITS]) || !(|w_mul[63:31+FRAC_BITS]));
        end else begin
            n_side.result = w_front.result;
            n_side.ovf    = w_front.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (w_adv) begin
            r_mv <= w_front_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_side     <= n_side;
            r_dividend <= {w_front.a_mag, {FRAC_BITS{1'b0}}};
            r_divisor  <= w_front.b_mag;
        end
    end

    fpa_divider #(
        .DW     (DivW),
        .SIDE_W (SideW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_adv),
        .i_valid    (r_mv),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .i_side     (r_side),
        .o_valid    (w_div_valid),
        .o_quotient (w_quot),
        .o_side     (w_side_bits)
    );

    assign w_side = t_side'(w_side_bits);
    assign w_qlow = w_quot[31:0];

    always_comb begin
        n_out              = '0;
        n_out.compare_true = w_side.cmp;
        if (w_side.is_div) begin
            if (w_side.dz) begin
                n_out.divide_by_zero = 1'b1;
            end else if (w_side.neg) begin
                n_out.result_value = -w_qlow;
                n_out.overflowed   = (|w_quot[DivW-1:32]) || (w_quot[31] && (|w_quot[30:0]));
            end else begin
                n_out.result_value = w_qlow;
                n_out.overflowed   = |w_quot[DivW-1:31];
            end
        end else begin
            n_out.result_value = w_side.result;
            n_out.overflowed   = w_side.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_out_dz    = o_out_valid && o_out_data.divide_by_zero;
    assign w_out_cmp   = o_out_valid && o_out_data.compare_true;
    assign w_res_clean = (o_out_data.result_value == '0) && !o_out_data.overflowed;
    assign w_cmp_clean = w_res_clean && !o_out_data.divide_by_zero;

    `FPA_ASSERT_SAME(a_dz_clean, i_clk, i_rst_n, w_out_dz, w_res_clean, "div by zero not clean")
    `FPA_ASSERT_SAME(a_cmp_clean, i_clk, i_rst_n, w_out_cmp, w_cmp_clean, "compare carries data")
    `FPA_ASSERT_NEXT(a_div_to_out, i_clk, i_rst_n, w_adv && w_div_valid, o_out_valid, "result lost")

endmodule

// ===== tb/fpa_checker.sv =====
// Checker for the fixed-point unit: watches both channels, predicts each result
// and compares it with what comes out. Depends on fpa_pkg.
`timescale 1ns / 100ps

module fpa_checker import fpa_pkg::*; #(
    parameter int unsigned FRAC_BITS = FracBitsDefault
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_errors,
    output int        o_pending
);

    t_out_item pending_results[$];

    // Wrap a 64-bit exact value to a word and flag when it does not fit.
    function automatic void wrap_word(input longint v, ref t_out_item r);
        r.result_value = v[31:0];
        r.overflowed   = (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

    function automatic t_out_item alu_result(input t_in_item it);
        t_out_item r;
        longint a;
        longint b;
        longint scale;
        a = it.operand_a;
        b = it.operand_b;
        scale = longint'(1) << FRAC_BITS;
        r = '0;
        case (t_cmd'(it.cmd))
            CMD_ADD:      wrap_word(a + b, r);
            CMD_SUB:      wrap_word(a - b, r);
            CMD_MUL:      wrap_word((a * b) / scale, r);
            CMD_DIV: begin
                if (b == 0) r.divide_by_zero = 1'b1;
                else wrap_word((a * scale) / b, r);
            end
            CMD_GT:       r.compare_true = a > b;
            CMD_LT:       r.compare_true = a < b;
            CMD_GE:       r.compare_true = a >= b;
            CMD_LE:       r.compare_true = a <= b;
            CMD_EQ:       r.compare_true = a == b;
            CMD_NE:       r.compare_true = a != b;
            CMD_MIN:      wrap_word(a < b ? a : b, r);
            CMD_MAX:      wrap_word(a > b ? a : b, r);
            CMD_INC:      wrap_word(a + 1, r);
            CMD_DEC:      wrap_word(a - 1, r);
            CMD_FROM_INT: wrap_word(a * scale, r);
            default:      wrap_word(a / scale, r);
        endcase
        return r;
    endfunction

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                pending_results.push_back(alu_result(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    o_errors = o_errors + 1;
                    $display("%0t: unexpected result expected none actual %h", $time,
                             i_out_data);
                end else begin
                    want = pending_results.pop_front();
                    if (want.result_value !== i_out_data.result_value) begin
                        o_errors = o_errors + 1;
                        $display("%0t: result_value expected %h actual %h", $time,
                                 want.result_value, i_out_data.result_value);
                    end
                    if (want.compare_true !== i_out_data.compare_true) begin
                        o_errors = o_errors + 1;
                        $display("%0t: compare_true expected %b actual %b", $time,
                                 want.compare_true, i_out_data.compare_true);
                    end
                    if (want.divide_by_zero !== i_out_data.divide_by_zero) begin
                        o_errors = o_errors + 1;
                        $display("%0t: divide_by_zero expected %b actual %b", $time,
                                 want.divide_by_zero, i_out_data.divide_by_zero);
                    end
                    if (want.overflowed !== i_out_data.overflowed) begin
                        o_errors = o_errors + 1;
                        $display("%0t: overflowed expected %b actual %b", $time,
                                 want.overflowed, i_out_data.overflowed);
                    end
                end
            end
        end
        o_pending = pending_results.size();
    end

endmodule

// ===== tb/tb_fixed_point_alu.sv =====
// Testbench top for the fixed-point unit: clock, reset, stimulus, output stalls
// and verdict. Depends on fpa_pkg, fixed_point_alu and fpa_checker.
`timescale 1ns / 100ps

module tb_fixed_point_alu;
    import fpa_pkg::*;

    localparam int unsigned FRAC_BITS = FracBitsDefault;
    localparam int          LATENCY   = FRAC_BITS + 34;
    localparam int          N_RANDOM  = 1230;
    localparam int          CYCLE_LIMIT = 200000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;
    int        errors;
    int        pending;
    int        cycle_count;
    bit        calm_phase;
    bit        hold_output;

    fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    fpa_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready), .i_out_data(o_out_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL fixed_point_alu");
            $finish;
        end
    end

    // Receiver: random stalls, none in the calm phase, a long hold on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= !hold_output && (calm_phase || $urandom_range(99) >= 27);
    end

    initial begin
        hold_output = 1'b0;
        wait (i_rst_n);
        repeat (300) @(posedge i_clk);
        hold_output = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_output = 1'b0;
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return 32'($signed($urandom_range(2000)) - 1000);
            4: return 32'($signed($urandom_range(512)) - 256) << 8;
            default: return $urandom;
        endcase
    endfunction

    // Hold valid high across back-to-back transfers; drop only when idling.
    task automatic send_item(input t_in_item it);
        while (!calm_phase && $urandom_range(99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_op(input t_cmd op, input logic [31:0] a, input logic [31:0] b);
        t_in_item it;
        it.cmd = op;
        it.operand_a = a;
        it.operand_b = b;
        send_item(it);
    endtask

    initial begin
        t_in_item it;
        t_cmd op;
        cycle_count = 0;
        calm_phase  = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every operation once on mixed operands, then the corners.
        op = op.first();
        do begin
            send_op(op, 32'h0000_0380, 32'hffff_fe80);
            op = op.next();
        end while (op != op.first());
        send_op(CMD_DIV, 32'h0000_0100, 32'h0);
        send_op(CMD_INC, 32'h7fff_ffff, 32'hffff_ffff);
        send_op(CMD_DEC, 32'h8000_0000, 32'h0);
        send_op(CMD_FROM_INT, 32'h0100_0000, 32'h0);
        send_op(CMD_TO_INT, 32'hffff_ff01, 32'h0);
        send_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(CMD_DIV, 32'h8000_0000, 32'h0000_0001);
        send_op(CMD_MIN, 32'h5, 32'h5);
        send_op(CMD_MAX, 32'h8000_0000, 32'h7fff_ffff);

        // Sender pause until everything has drained.
        i_in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            calm_phase = (n >= 600 && n < 800);
            it.cmd = 4'($urandom_range(15));
            it.operand_a = pick_word();
            it.operand_b = pick_word();
            send_item(it);
        end
        i_in_valid <= 1'b0;
        calm_phase = 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) $display("PASS fixed_point_alu");
        else $display("FAIL fixed_point_alu");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/fpa_pkg.sv
design/fpa_front.sv
design/fpa_divider.sv
design/fixed_point_alu.sv
tb/fpa_checker.sv
tb/tb_fixed_point_alu.sv
